### sv/srhg_pkg.sv
// Package with the payload types, state type and constants of the sensor register health gate.
package srhg_pkg;

    localparam int REG_BYTES = 7;

    localparam logic [2:0] STATUS_WAITING   = 3'd0;
    localparam logic [2:0] STATUS_XFER_FAIL = 3'd1;
    localparam logic [2:0] STATUS_ZERO_DATA = 3'd2;
    localparam logic [2:0] STATUS_SETTLING  = 3'd3;
    localparam logic [2:0] STATUS_OK        = 3'd4;

    localparam logic [1:0] ACTION_NONE    = 2'd0;
    localparam logic [1:0] ACTION_REWRITE = 2'd1;
    localparam logic [1:0] ACTION_RESET   = 2'd2;

    localparam logic [63:0] RESET_WAIT_US   = 64'd10000;
    localparam logic [63:0] REWRITE_WAIT_US = 64'd3000;
    localparam logic [4:0]  SETTLE_POLLS    = 5'd20;
    localparam logic [31:0] ERROR_MAX       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [63:0]        now_us;
        logic               transfer_ok;
        logic [7:0]         reg_readback;
        logic [7:0]         temp_raw;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } poll_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [1:0]         fix_action;
        logic [2:0]         fix_index;
        logic [7:0]         fix_value;
        logic [2:0]         next_check_index;
        logic [7:0]         out_temp;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [31:0]        fault_total;
    } result_t;

    typedef struct packed {
        logic [2:0]  check_index;
        logic [4:0]  settle_count;
        logic [63:0] recovery_deadline;
        logic [31:0] fault_total;
    } gate_state_t;

endpackage

### sv/sensor_register_health_gate.sv
// Top level of the sensor register health gate: input register, poll evaluation, result register.
// An accepted poll is held in the input register, evaluated from there, and moves into the
// result register once that register is free, from where it transfers to the output.
// Throughput: one poll per cycle while no result stalls; the registers form a two-deep pipeline.
// A stalled result holds its register and the input register, after which input ready drops.
// Reset (aresetn low, synchronous) clears the check index, settle count, deadline, error count,
// the expected register and both pipeline valid flags.
module sensor_register_health_gate #(
    parameter int CHECKED_REGS = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  srhg_pkg::poll_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output srhg_pkg::result_t m_data,
    input  logic              cfg_we,
    input  logic [55:0]       cfg_wdata
);

    logic                  in_valid_reg;
    srhg_pkg::poll_t       in_data_reg;
    logic                  out_valid_reg;
    srhg_pkg::result_t     out_data_reg;
    srhg_pkg::gate_state_t state_reg;
    srhg_pkg::gate_state_t state_next;
    srhg_pkg::result_t     core_result;
    logic [55:0]           expected_reg;
    logic                  out_free;
    logic                  advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    srhg_poll_core #(
        .CHECKED_REGS(CHECKED_REGS)
    ) u_core (
        .poll           (in_data_reg),
        .state_cur      (state_reg),
        .expected_values(expected_reg),
        .result         (core_result),
        .state_next     (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            expected_reg  <= '0;
        end else begin
            if (cfg_we) begin
                expected_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    // A poll that leaves the input register always shows up as a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("Advanced poll did not produce a result.");

    // An accepted sample never comes with a fix request and leaves no settling behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && core_result.status == srhg_pkg::STATUS_OK) |->
            (core_result.fix_action == srhg_pkg::ACTION_NONE &&
             state_next.settle_count == 5'd0))
        else $error("Sample accepted while a fix or settling was pending.");

    // The round-robin index stays within the checked registers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(state_reg.check_index) < CHECKED_REGS)
        else $error("Check index out of range.");

    // The error count only grows.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> state_reg.fault_total >= $past(state_reg.fault_total))
        else $error("Error count decreased.");

endmodule

### sv/srhg_poll_core.sv
// Combinational evaluation of one poll against the gate state.
module srhg_poll_core #(
    parameter int CHECKED_REGS = 7
) (
    input  srhg_pkg::poll_t     poll,
    input  srhg_pkg::gate_state_t state_cur,
    input  logic [55:0]         expected_values,
    output srhg_pkg::result_t   result,
    output srhg_pkg::gate_state_t state_next
);

    logic [7:0]  expected_byte;
    logic        mismatch;
    logic        zero_data;
    logic [2:0]  idx;
    logic [4:0]  settle;
    logic [32:0] error_sum;

    always_comb begin
        expected_byte = 8'd0;
        if (int'(state_cur.check_index) < srhg_pkg::REG_BYTES) begin
            expected_byte = expected_values[{state_cur.check_index, 3'b000} +: 8];
        end
        mismatch  = poll.reg_readback != expected_byte;
        zero_data = (poll.temp_raw == 8'd0) && (poll.rate_x == 16'sd0) &&
                    (poll.rate_y == 16'sd0) && (poll.rate_z == 16'sd0);
        idx       = state_cur.check_index;
        settle    = state_cur.settle_count;
        error_sum = {1'b0, state_cur.fault_total};

        state_next = state_cur;
        result     = '0;
        result.status = srhg_pkg::STATUS_WAITING;

        if (poll.now_us < state_cur.recovery_deadline) begin
            result.status = srhg_pkg::STATUS_WAITING;
        end else if (!poll.transfer_ok) begin
            result.status = srhg_pkg::STATUS_XFER_FAIL;
        end else begin
            if (mismatch) begin
                error_sum = error_sum + 33'd1;
                if (settle == 5'd0 || idx == 3'd0) begin
                    result.fix_action = srhg_pkg::ACTION_RESET;
                    state_next.recovery_deadline = poll.now_us + srhg_pkg::RESET_WAIT_US;
                    idx = 3'd0;
                end else begin
                    result.fix_action = srhg_pkg::ACTION_REWRITE;
                    result.fix_index  = idx;
                    result.fix_value  = expected_byte;
                    state_next.recovery_deadline = poll.now_us + srhg_pkg::REWRITE_WAIT_US;
                end
                settle = srhg_pkg::SETTLE_POLLS;
            end
            if (idx == 3'(CHECKED_REGS - 1)) begin
                state_next.check_index = 3'd0;
            end else begin
                state_next.check_index = idx + 3'd1;
            end

            if (zero_data) begin
                error_sum = error_sum + 33'd1;
                result.status = srhg_pkg::STATUS_ZERO_DATA;
            end else if (settle != 5'd0) begin
                settle = settle - 5'd1;
                result.status = srhg_pkg::STATUS_SETTLING;
            end else begin
                result.status   = srhg_pkg::STATUS_OK;
                result.out_temp = poll.temp_raw;
                result.out_x    = poll.rate_x;
                result.out_y    = poll.rate_y;
                result.out_z    = poll.rate_z;
            end
            state_next.settle_count = settle;
        end

        if (error_sum[32]) begin
            state_next.fault_total = srhg_pkg::ERROR_MAX;
        end else begin
            state_next.fault_total = error_sum[31:0];
        end
        result.next_check_index = state_next.check_index;
        result.fault_total      = state_next.fault_total;
    end

endmodule
